>>> hw/rtl/bng_pkg.sv
// ---------------------------------------------------------------------------
// bng_pkg
// shared constants, types and helpers of the backprop gradient block
// ---------------------------------------------------------------------------
package bng_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int GRAD_DEPTH = 256;
   localparam int GRAD_AW    = $clog2(GRAD_DEPTH);
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 8;
   localparam int ACC_W      = 64;
   localparam int MUL_W      = DATA_W + 1;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SAT_W      = PROD_W + 2;
   localparam int DIVD_W     = FRAC_BITS + DATA_W + 2;
   localparam int DVSR_W     = FRAC_BITS + 1;
   localparam int DCNT_W     = $clog2(DIVD_W + 1);
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam longint ONE_Q  = longint'(1) << FRAC_BITS;

   // action codes
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_WEIGHT = 2'd1;
   localparam logic [1:0] ACT_OUTPUT = 2'd2;

   // loss codes
   localparam logic [1:0] LOSS_MSE = 2'd0;
   localparam logic [1:0] LOSS_BCE = 2'd1;

   // activation codes
   localparam logic [1:0] ACTV_RELU    = 2'd0;
   localparam logic [1:0] ACTV_SIGMOID = 2'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_ACC,
      ST_DER,
      ST_DSAT,
      ST_FIN,
      ST_SHF,
      ST_DIV_A,
      ST_WAIT_A,
      ST_DIV_B,
      ST_WAIT_B,
      ST_LOSS,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIVD_W-1:0] dividend;
      logic [DVSR_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DIVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     clip;
   } sat_type;

   // clip a wide signed value to the 32-bit range
   function automatic sat_type sat32(input logic signed [SAT_W-1:0] v);
      sat_type r;
      r.clip = !((&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1]));
      if (!r.clip) begin
         r.data = v[DATA_W-1:0];
      end else if (v[SAT_W-1]) begin
         r.data = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r.data = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/bng_ram.sv
// ---------------------------------------------------------------------------
// bng_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
module bng_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bng_div.sv
// ---------------------------------------------------------------------------
// bng_div
// serial signed divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
module bng_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bng_pkg::div_req_type div_req,
   output bng_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [bng_pkg::DCNT_W-1:0]    cnt_ff, cnt_in;
   logic [bng_pkg::DVSR_W-1:0]    dvsr_ff, dvsr_in;
   logic [bng_pkg::DVSR_W-1:0]    rem_ff, rem_in;
   logic [bng_pkg::DIVD_W-1:0]    quo_ff, quo_in;
   logic [bng_pkg::DVSR_W:0]      shifted;
   logic [bng_pkg::DVSR_W:0]      diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvsr_in = dvsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[bng_pkg::DIVD_W-1]};
      diff    = shifted - {1'b0, dvsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[bng_pkg::DIVD_W-1];
         quo_in  = neg_in ? -div_req.dividend : div_req.dividend;
         rem_in  = '0;
         dvsr_in = div_req.divisor;
         cnt_in  = bng_pkg::DCNT_W'(bng_pkg::DIVD_W);
      end else if (busy_ff) begin
         if (!diff[bng_pkg::DVSR_W]) begin
            rem_in = diff[bng_pkg::DVSR_W-1:0];
            quo_in = {quo_ff[bng_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[bng_pkg::DVSR_W-1:0];
            quo_in = {quo_ff[bng_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bng_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

>>> hw/rtl/backprop_neuron_gradient.sv
// ---------------------------------------------------------------------------
// backprop_neuron_gradient
// backpropagation delta unit in q16.16 fixed point
// ---------------------------------------------------------------------------
// One beat is worked on at a time. A load beat writes the next-layer gradient
// memory. A weight beat reads that memory, runs one multiply and one
// saturating accumulate; the last weight of a neuron then goes on to the
// activation derivative, the final multiply and the result register.
// An output beat with categorical loss goes straight to the result register;
// squared error uses the serial divider once, cross-entropy uses it twice.
// The divider sets the slow path, the single shared 33x33 multiplier the
// hidden path. A result waits in the rsp register while the next beat is
// taken, but the next result is not finished until that register is free.
// Configuration is to be written only while idle; the block itself does
// not enforce this.
// ---------------------------------------------------------------------------
module backprop_neuron_gradient (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [bng_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bng_pkg::COUNT_W-1:0]        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_action,
   input  logic [bng_pkg::IDX_W-1:0]          req_index,
   input  logic signed [bng_pkg::DATA_W-1:0]  req_operand,
   input  logic signed [bng_pkg::DATA_W-1:0]  req_target,
   input  logic signed [bng_pkg::DATA_W-1:0]  req_neuron_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bng_pkg::DATA_W-1:0]  rsp_gradient,
   output logic                               rsp_neuron_kind,
   output logic [bng_pkg::IDX_W-1:0]          rsp_neuron_index,
   output logic                               rsp_saturated
);

   localparam int DW = bng_pkg::DATA_W;

   // configuration
   logic [1:0]                    loss_ff;
   logic [1:0]                    actv_ff;
   logic [bng_pkg::COUNT_W-1:0]   count_ff;

   bng_pkg::state_type            state_ff, state_in;

   // captured beat
   logic [1:0]                    act_ff, act_in;
   logic [bng_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic signed [DW-1:0]          op_ff, op_in;
   logic signed [DW-1:0]          tgt_ff, tgt_in;
   logic signed [DW-1:0]          val_ff, val_in;
   logic                          last_ff, last_in;

   // datapath
   logic signed [bng_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [bng_pkg::IDX_W-1:0]         hcnt_ff, hcnt_in;
   logic signed [bng_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic signed [DW-1:0]              s_ff, s_in;
   logic signed [DW-1:0]              d_ff, d_in;
   logic signed [bng_pkg::DIVD_W-1:0] q1_ff, q1_in;
   logic signed [DW-1:0]              res_ff, res_in;
   logic                              flag_ff, flag_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]          rsp_grad_ff, rsp_grad_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [bng_pkg::IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   logic signed [bng_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [bng_pkg::ACC_W:0]    acc_sum;
   logic signed [DW-1:0]              pred_clamp;
   logic [bng_pkg::DVSR_W-1:0]        pc;
   logic [bng_pkg::DVSR_W-1:0]        n_div;
   logic signed [bng_pkg::SAT_W-1:0]  d_raw;
   bng_pkg::sat_type                  sat_s, sat_d, sat_g, sat_loss, sat_cce;
   logic                              out_free;
   logic                              req_take;
   logic                              is_bce;

   logic                              ram_we;
   logic [bng_pkg::GRAD_AW-1:0]       ram_waddr;
   logic [DW-1:0]                     ram_wdata;
   logic [DW-1:0]                     ram_rdata;

   bng_pkg::div_req_type              div_req;
   bng_pkg::div_rsp_type              div_rsp;

   bng_ram #(
      .WIDTH (DW),
      .DEPTH (bng_pkg::GRAD_DEPTH)
   ) u_grad_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (bng_pkg::GRAD_AW'(req_index)),
      .rd_data (ram_rdata)
   );

   bng_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loss_ff  <= bng_pkg::LOSS_MSE;
         actv_ff  <= bng_pkg::ACTV_RELU;
         count_ff <= bng_pkg::COUNT_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            bng_pkg::CSR_LOSS:  loss_ff  <= csr_wdata[1:0];
            bng_pkg::CSR_ACTV:  actv_ff  <= csr_wdata[1:0];
            bng_pkg::CSR_COUNT: count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != bng_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_bce    = (loss_ff == bng_pkg::LOSS_BCE);

   // shared multiplier operands by state
   always_comb begin
      mul_a = $signed({{(bng_pkg::MUL_W-DW){ram_rdata[DW-1]}}, ram_rdata});
      mul_b = bng_pkg::MUL_W'(op_ff);
      unique case (state_ff)
         bng_pkg::ST_DER: begin
            mul_a = bng_pkg::MUL_W'(val_ff);
            if (actv_ff == bng_pkg::ACTV_SIGMOID) begin
               mul_b = bng_pkg::MUL_W'(bng_pkg::ONE_Q) - bng_pkg::MUL_W'(val_ff);
            end else begin
               mul_b = bng_pkg::MUL_W'(val_ff);
            end
         end
         bng_pkg::ST_FIN: begin
            mul_a = bng_pkg::MUL_W'(s_ff);
            mul_b = bng_pkg::MUL_W'(d_ff);
         end
         default: ;
      endcase
   end

   // accumulate of the product, saturated in the accumulate state
   always_comb begin
      acc_sum = (bng_pkg::ACC_W + 1)'(acc_ff) + mul_ff[bng_pkg::ACC_W:0];
   end

   // prediction clamp for cross-entropy, divisor for squared error
   always_comb begin
      if (val_ff < DW'(1)) begin
         pred_clamp = DW'(1);
      end else if (val_ff > DW'(bng_pkg::ONE_Q - 1)) begin
         pred_clamp = DW'(bng_pkg::ONE_Q - 1);
      end else begin
         pred_clamp = val_ff;
      end
      pc    = pred_clamp[bng_pkg::DVSR_W-1:0];
      n_div = (count_ff == '0) ? bng_pkg::DVSR_W'(1) : bng_pkg::DVSR_W'(count_ff);
   end

   // derivative before clipping
   always_comb begin
      if (actv_ff == bng_pkg::ACTV_RELU) begin
         d_raw = (val_ff > 0) ? bng_pkg::SAT_W'(bng_pkg::ONE_Q) : '0;
      end else if (actv_ff == bng_pkg::ACTV_SIGMOID) begin
         d_raw = bng_pkg::SAT_W'(mul_ff >>> bng_pkg::FRAC_BITS);
      end else begin
         d_raw = bng_pkg::SAT_W'(bng_pkg::ONE_Q) - bng_pkg::SAT_W'(mul_ff >>> bng_pkg::FRAC_BITS);
      end
   end

   assign sat_s    = bng_pkg::sat32(bng_pkg::SAT_W'(acc_ff >>> bng_pkg::FRAC_BITS));
   assign sat_d    = bng_pkg::sat32(d_raw);
   assign sat_g    = bng_pkg::sat32(bng_pkg::SAT_W'(mul_ff >>> bng_pkg::FRAC_BITS));
   assign sat_loss = bng_pkg::sat32(bng_pkg::SAT_W'(div_rsp.quotient) - bng_pkg::SAT_W'(q1_ff));
   assign sat_cce  = bng_pkg::sat32(bng_pkg::SAT_W'(req_neuron_value)
                                    - bng_pkg::SAT_W'(req_target));

   // sequencer
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      tgt_in   = tgt_ff;
      val_in   = val_ff;
      last_in  = last_ff;
      acc_in   = acc_ff;
      hcnt_in  = hcnt_ff;
      mul_in   = mul_a * mul_b;
      s_in     = s_ff;
      d_in     = d_ff;
      q1_in    = q1_ff;
      res_in   = res_ff;
      flag_in  = flag_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_grad_in  = rsp_grad_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      ram_we    = 1'b0;
      ram_waddr = bng_pkg::GRAD_AW'(req_index);
      ram_wdata = req_operand;

      div_req.start    = 1'b0;
      div_req.dividend = (bng_pkg::DIVD_W'(val_ff) - bng_pkg::DIVD_W'(tgt_ff)) <<< 1;
      div_req.divisor  = n_div;

      unique case (state_ff)
         bng_pkg::ST_IDLE: begin
            if (req_take) begin
               act_in  = req_action;
               idx_in  = req_index;
               op_in   = req_operand;
               tgt_in  = req_target;
               val_in  = req_neuron_value;
               last_in = req_last;
               flag_in = 1'b0;
               priority if (req_action == bng_pkg::ACT_LOAD) begin
                  ram_we = 1'b1;
               end else if (req_action == bng_pkg::ACT_WEIGHT) begin
                  state_in = bng_pkg::ST_MAC;
               end else if (req_action == bng_pkg::ACT_OUTPUT) begin
                  if (loss_ff == bng_pkg::LOSS_MSE || loss_ff == bng_pkg::LOSS_BCE) begin
                     state_in = bng_pkg::ST_DIV_A;
                  end else begin
                     res_in   = sat_cce.data;
                     flag_in  = sat_cce.clip;
                     state_in = bng_pkg::ST_EMIT;
                  end
               end else begin
                  state_in = bng_pkg::ST_IDLE;
               end
            end
         end
         bng_pkg::ST_MAC: begin
            // memory data is valid now, product registered
            state_in = bng_pkg::ST_ACC;
         end
         bng_pkg::ST_ACC: begin
            if (acc_sum[bng_pkg::ACC_W] != acc_sum[bng_pkg::ACC_W-1]) begin
               acc_in = acc_sum[bng_pkg::ACC_W] ? {1'b1, {(bng_pkg::ACC_W-1){1'b0}}}
                                                : {1'b0, {(bng_pkg::ACC_W-1){1'b1}}};
            end else begin
               acc_in = acc_sum[bng_pkg::ACC_W-1:0];
            end
            state_in = last_ff ? bng_pkg::ST_DER : bng_pkg::ST_IDLE;
         end
         bng_pkg::ST_DER: begin
            s_in     = sat_s.data;
            flag_in  = flag_ff | sat_s.clip;
            state_in = bng_pkg::ST_DSAT;
         end
         bng_pkg::ST_DSAT: begin
            d_in     = sat_d.data;
            flag_in  = flag_ff | sat_d.clip;
            state_in = bng_pkg::ST_FIN;
         end
         bng_pkg::ST_FIN: begin
            state_in = bng_pkg::ST_SHF;
         end
         bng_pkg::ST_SHF: begin
            res_in   = sat_g.data;
            flag_in  = flag_ff | sat_g.clip;
            state_in = bng_pkg::ST_EMIT;
         end
         bng_pkg::ST_DIV_A: begin
            div_req.start = 1'b1;
            if (is_bce) begin
               div_req.dividend = bng_pkg::DIVD_W'(tgt_ff) <<< bng_pkg::FRAC_BITS;
               div_req.divisor  = pc;
            end
            state_in = bng_pkg::ST_WAIT_A;
         end
         bng_pkg::ST_WAIT_A: begin
            if (div_rsp.done) begin
               if (is_bce) begin
                  q1_in    = div_rsp.quotient;
                  state_in = bng_pkg::ST_DIV_B;
               end else begin
                  q1_in    = '0;
                  state_in = bng_pkg::ST_LOSS;
               end
            end
         end
         bng_pkg::ST_DIV_B: begin
            div_req.start    = 1'b1;
            div_req.dividend = (bng_pkg::DIVD_W'(bng_pkg::ONE_Q) - bng_pkg::DIVD_W'(tgt_ff))
                               <<< bng_pkg::FRAC_BITS;
            div_req.divisor  = bng_pkg::DVSR_W'(bng_pkg::ONE_Q) - pc;
            state_in = bng_pkg::ST_WAIT_B;
         end
         bng_pkg::ST_WAIT_B: begin
            if (div_rsp.done) begin
               state_in = bng_pkg::ST_LOSS;
            end
         end
         bng_pkg::ST_LOSS: begin
            res_in   = sat_loss.data;
            flag_in  = sat_loss.clip;
            state_in = bng_pkg::ST_EMIT;
         end
         bng_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_grad_in  = res_ff;
               rsp_sat_in   = flag_ff;
               if (act_ff == bng_pkg::ACT_WEIGHT) begin
                  // hidden result: close out the neuron
                  rsp_kind_in = 1'b1;
                  rsp_idx_in  = hcnt_ff;
                  hcnt_in     = hcnt_ff + 1'b1;
                  acc_in      = '0;
               end else begin
                  // output result also feeds the layer below
                  rsp_kind_in = 1'b0;
                  rsp_idx_in  = idx_ff;
                  ram_we      = 1'b1;
                  ram_waddr   = bng_pkg::GRAD_AW'(idx_ff);
                  ram_wdata   = res_ff;
               end
               state_in = bng_pkg::ST_IDLE;
            end
         end
         default: state_in = bng_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bng_pkg::ST_IDLE;
         acc_ff       <= '0;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      tgt_ff      <= tgt_in;
      val_ff      <= val_in;
      last_ff     <= last_in;
      mul_ff      <= mul_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      q1_ff       <= q1_in;
      res_ff      <= res_in;
      flag_ff     <= flag_in;
      rsp_grad_ff <= rsp_grad_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gradient     = rsp_grad_ff;
   assign rsp_neuron_kind  = rsp_kind_ff;
   assign rsp_neuron_index = rsp_idx_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

>>> hw/rtl/bng_checker.sv
// ---------------------------------------------------------------------------
// bng_checker
// port-level checks of the backprop gradient block
// ---------------------------------------------------------------------------
module bng_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [1:0]                         req_action,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [bng_pkg::DATA_W-1:0]  rsp_gradient,
   input logic                               rsp_neuron_kind,
   input logic                               rsp_saturated
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient))
      else $error("rsp beat changed under stall");

   // an output beat keeps the input stalled while it is worked on
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == bng_pkg::ACT_OUTPUT |=> req_stall)
      else $error("input taken during output beat");

   // a clipped output gradient sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_neuron_kind && rsp_saturated |->
      rsp_gradient == {1'b0, {(bng_pkg::DATA_W-1){1'b1}}} ||
      rsp_gradient == {1'b1, {(bng_pkg::DATA_W-1){1'b0}}})
      else $error("saturated flag without clipped value");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat out of reset");

endmodule

bind backprop_neuron_gradient bng_checker u_bng_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_gradient    (rsp_gradient),
   .rsp_neuron_kind (rsp_neuron_kind),
   .rsp_saturated   (rsp_saturated)
);
